>>> rtl/core/cpt_pkg.sv
package cpt_pkg;

   // Coordinate width of the tracked position.
   localparam int COORD_BITS = 16;
   localparam logic [32:0] COORD_MASK = (33'd1 << COORD_BITS) - 33'd1;

   // Fixed field widths.
   localparam int MOUSE_BITS     = 16;
   localparam int SCREEN_BITS    = 16;
   localparam int HANDLE_BITS    = 32;
   localparam int TTY_BITS       = 8;
   localparam int BTN_BITS       = 8;
   localparam int ACTION_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // Signed delta and the sum used when saturating the goal.
   localparam int DELTA_BITS = MOUSE_BITS + 1;
   localparam int SUM_BITS   = ((COORD_BITS > DELTA_BITS) ? COORD_BITS : DELTA_BITS) + 2;

   // Stream payload sizes.
   localparam int REQ_PAYLOAD_BITS = 4 * MOUSE_BITS + BTN_BITS + 1 + TTY_BITS + 1;
   localparam int REQ_TDATA_BITS   = ((REQ_PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RSP_PAYLOAD_BITS = TTY_BITS + 1 + 2 * COORD_BITS + BTN_BITS
                                     + 2 * HANDLE_BITS;
   localparam int RSP_TDATA_BITS   = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   // Commands produced by one sync, and the output queue.
   localparam int SYNC_MAX     = 3;
   localparam int CNT_BITS     = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   localparam logic [ACTION_BITS-1:0] ACT_MOUSE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd2;

   // Command kinds.
   localparam logic CMD_TERM  = 1'b0;
   localparam logic CMD_PLANE = 1'b1;

   // Cursor plane modes.
   localparam logic [1:0] MODE_HIDDEN  = 2'd0;
   localparam logic [1:0] MODE_SHOWN   = 2'd1;
   localparam logic [1:0] MODE_UNKNOWN = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_MAX_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_MAX_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PLANE_ID     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FB_HANDLE    = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0]       action;
      logic signed [MOUSE_BITS-1:0] abs_x;
      logic signed [MOUSE_BITS-1:0] abs_y;
      logic signed [MOUSE_BITS-1:0] rel_dx;
      logic signed [MOUSE_BITS-1:0] rel_dy;
      logic [BTN_BITS-1:0]          button_mask;
      logic                         term_active;
      logic [TTY_BITS-1:0]          term_tty;
      logic                         term_accepts;
   } req_type;

   typedef struct packed {
      logic                   command;
      logic [TTY_BITS-1:0]    target_tty;
      logic                   shown;
      coord_type              pos_x;
      coord_type              pos_y;
      logic [BTN_BITS-1:0]    buttons_out;
      logic [HANDLE_BITS-1:0] fb_out;
      logic [HANDLE_BITS-1:0] plane_out;
      logic                   last;
   } rsp_type;

   // What was last sent to the terminal and to the plane.
   typedef struct packed {
      logic                term_shown;
      logic [TTY_BITS-1:0] term_tty;
      coord_type           term_x;
      coord_type           term_y;
      logic [BTN_BITS-1:0] term_buttons;
      logic [1:0]          plane_mode;
      coord_type           plane_x;
      coord_type           plane_y;
   } sync_state_type;

   localparam sync_state_type SYNC_CLEAR = '{
      term_shown:   1'b0,
      term_tty:     '0,
      term_x:       '0,
      term_y:       '0,
      term_buttons: '0,
      plane_mode:   MODE_UNKNOWN,
      plane_x:      '0,
      plane_y:      '0
   };

   function automatic rsp_type make_cmd(
      input logic                   cmd,
      input logic [TTY_BITS-1:0]    tty,
      input logic                   shown,
      input coord_type              x,
      input coord_type              y,
      input logic [BTN_BITS-1:0]    btn,
      input logic [HANDLE_BITS-1:0] fb,
      input logic [HANDLE_BITS-1:0] plane
   );
      rsp_type r;
      r.command     = cmd;
      r.target_tty  = tty;
      r.shown       = shown;
      r.pos_x       = x;
      r.pos_y       = y;
      r.buttons_out = btn;
      r.fb_out      = fb;
      r.plane_out   = plane;
      r.last        = 1'b0;
      return r;
   endfunction

   // Largest usable coordinate: the screen maximum clipped to the coordinate range.
   function automatic coord_type coord_limit(input logic [SCREEN_BITS-1:0] m);
      if (33'(m) > COORD_MASK) begin
         return coord_type'(COORD_MASK);
      end
      return coord_type'(m);
   endfunction

   // Screen center, (max + 1) / 2, wrapped into the coordinate range.
   function automatic coord_type center_of(input logic [SCREEN_BITS-1:0] m);
      logic [SCREEN_BITS:0] s;
      s = {1'b0, m} + {{SCREEN_BITS{1'b0}}, 1'b1};
      return coord_type'(s[SCREEN_BITS:1]);
   endfunction

   // goal + d, clamped to [0, lim].
   function automatic coord_type sat_coord(
      input coord_type                    goal,
      input logic signed [DELTA_BITS-1:0] d,
      input coord_type                    lim
   );
      logic signed [SUM_BITS-1:0] v;
      logic signed [SUM_BITS-1:0] lim_ext;
      v       = $signed(SUM_BITS'(goal)) + SUM_BITS'(d);
      lim_ext = $signed(SUM_BITS'(lim));
      if (v < 0) begin
         return '0;
      end
      if (v > lim_ext) begin
         return lim;
      end
      return coord_type'(v);
   endfunction

endpackage

>>> rtl/core/cpt_sync.sv
// Builds the ordered list of cursor commands for one sync and the
// output memory that follows from it. Only changed content is sent.
module cpt_sync
   import cpt_pkg::*;
(
   input  sync_state_type           st_in,
   input  logic                     active,
   input  logic [TTY_BITS-1:0]      tty,
   input  logic                     accepts,
   input  coord_type                pos_x,
   input  coord_type                pos_y,
   input  logic [BTN_BITS-1:0]      buttons,
   input  logic [HANDLE_BITS-1:0]   plane_id,
   input  logic [HANDLE_BITS-1:0]   fb_handle,
   output sync_state_type           st_out,
   output logic [CNT_BITS-1:0]      cmd_cnt,
   output rsp_type [SYNC_MAX-1:0]   cmds
);

   sync_state_type      st;
   logic                term_path;
   logic [CNT_BITS-1:0] n;

   always_comb begin
      st        = st_in;
      term_path = active;
      n         = '0;
      cmds      = '0;

      if (active) begin
         // A different terminal took over: hide the pointer on the old one.
         if (st.term_shown && (st.term_tty != tty)) begin
            cmds[n] = make_cmd(CMD_TERM, st.term_tty, 1'b0, st.term_x, st.term_y,
                               st.term_buttons, '0, '0);
            n = n + 1'b1;
            st.term_shown = 1'b0;
         end
         if (!st.term_shown || (st.term_x != pos_x) || (st.term_y != pos_y) ||
             (st.term_buttons != buttons)) begin
            cmds[n] = make_cmd(CMD_TERM, tty, 1'b1, pos_x, pos_y, buttons, '0, '0);
            n = n + 1'b1;
            if (!accepts) begin
               term_path = 1'b0;
            end else begin
               st.term_shown   = 1'b1;
               st.term_tty     = tty;
               st.term_x       = pos_x;
               st.term_y       = pos_y;
               st.term_buttons = buttons;
            end
         end
      end

      if (term_path) begin
         if (st.plane_mode != MODE_HIDDEN) begin
            cmds[n] = make_cmd(CMD_PLANE, '0, 1'b0, pos_x, pos_y, '0, '0, plane_id);
            n = n + 1'b1;
            st.plane_mode = MODE_HIDDEN;
         end
      end else begin
         if (st.term_shown) begin
            cmds[n] = make_cmd(CMD_TERM, st.term_tty, 1'b0, st.term_x, st.term_y,
                               st.term_buttons, '0, '0);
            n = n + 1'b1;
            st.term_shown = 1'b0;
         end
         if ((st.plane_mode != MODE_SHOWN) || (st.plane_x != pos_x) ||
             (st.plane_y != pos_y)) begin
            cmds[n] = make_cmd(CMD_PLANE, '0, 1'b1, pos_x, pos_y, '0, fb_handle,
                               plane_id);
            n = n + 1'b1;
            st.plane_mode = MODE_SHOWN;
            st.plane_x    = pos_x;
            st.plane_y    = pos_y;
         end
      end

      for (int i = 0; i < SYNC_MAX; i++) begin
         cmds[i].last = ((CNT_BITS'(i) + 1'b1) == n);
      end
   end

   assign st_out  = st;
   assign cmd_cnt = n;

endmodule

>>> rtl/core/cpt_queue.sv
// Small output queue: takes up to three commands at once, hands out one
// per transfer. Room means a full burst fits after this cycle's pop.
module cpt_queue
   import cpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_BITS-1:0]    push_cnt,
   input  rsp_type [SYNC_MAX-1:0] push_data,
   input  logic                   pop,
   output rsp_type                head,
   output logic                   not_empty,
   output logic                   room
);

   rsp_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic [QCNT_BITS-1:0]  count_after_pop;

   assign not_empty       = (count_ff != '0);
   assign head            = entry_ff[rd_ptr_ff];
   assign count_after_pop = count_ff - QCNT_BITS'(pop);
   assign room            = (count_after_pop <= QCNT_BITS'(QUEUE_DEPTH - SYNC_MAX));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_after_pop + QCNT_BITS'(push_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SYNC_MAX; i++) begin
         if (CNT_BITS'(i) < push_cnt) begin
            entry_ff[wr_ptr_ff + QPTR_BITS'(i)] <= push_data[i];
         end
      end
   end

endmodule

>>> rtl/core/cursor_position_tracker_unit.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid/req_tready    tdata: pointer and terminal fields, tuser: kind
// rsp_      out        rsp_tvalid/rsp_tready    tdata: command fields, tuser: command, tlast
// csr_      in         csr_wr_en (no wait)      csr_index selects one of four registers
//
// An accepted item is held in the input register and then executed: mouse items
// update the goal, ticks and starts run the sync logic and push up to three
// commands into a four-entry output queue, and each command leaves in its own
// transfer. Execution waits only until the queue has room for three commands
// after this cycle's transfer; until then the input register holds its item and
// refuses new ones.
// Reset is synchronous and clears all tracking state and the queue.
module cursor_position_tracker_unit
   import cpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Input items.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // From bit 0: abs_x, abs_y, rel_dx, rel_dy, button_mask, term_active,
   // term_tty, term_accepts, zero fill.
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // action
   input  logic [ACTION_BITS-1:0]    req_tuser,
   // Result commands.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // From bit 0: target_tty, shown, pos_x, pos_y, buttons_out, fb_out,
   // plane_out, zero fill.
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // command
   output logic [0:0]                rsp_tuser,
   output logic                      rsp_tlast,
   // Configuration writes.
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Input register.
   req_type req_ff;
   logic    req_valid_ff;
   logic    fire;

   // Configuration registers.
   logic [SCREEN_BITS-1:0] screen_max_x_ff;
   logic [SCREEN_BITS-1:0] screen_max_y_ff;
   logic [HANDLE_BITS-1:0] plane_id_ff;
   logic [HANDLE_BITS-1:0] fb_handle_ff;

   // Tracking state.
   coord_type                    cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type                    goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [MOUSE_BITS-1:0] prev_abs_x_ff, prev_abs_x_in;
   logic signed [MOUSE_BITS-1:0] prev_abs_y_ff, prev_abs_y_in;
   logic                         abs_seen_ff, abs_seen_in;
   logic [BTN_BITS-1:0]          held_buttons_ff, held_buttons_in;
   logic                         move_pending_ff, move_pending_in;
   sync_state_type               sync_st_ff, sync_st_in;

   // Execute-stage signals.
   logic signed [DELTA_BITS-1:0] delta_x, delta_y;
   logic                         is_start;
   coord_type                    center_x, center_y;
   sync_state_type               sync_src, sync_res;
   coord_type                    sync_x, sync_y;
   logic [BTN_BITS-1:0]          sync_b;
   logic [CNT_BITS-1:0]          sync_cnt, push_cnt;
   rsp_type [SYNC_MAX-1:0]       sync_cmds;

   // Output queue.
   rsp_type q_head;
   logic    q_not_empty;
   logic    q_room;
   logic    rsp_xfer;

   // The item in the input register executes once the queue can take a full burst.
   assign fire       = req_valid_ff && q_room;
   assign req_tready = !req_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.action       <= req_tuser;
         req_ff.abs_x        <= req_tdata[15:0];
         req_ff.abs_y        <= req_tdata[31:16];
         req_ff.rel_dx       <= req_tdata[47:32];
         req_ff.rel_dy       <= req_tdata[63:48];
         req_ff.button_mask  <= req_tdata[71:64];
         req_ff.term_active  <= req_tdata[72];
         req_ff.term_tty     <= req_tdata[80:73];
         req_ff.term_accepts <= req_tdata[81];
      end
   end

   // The user must issue configuration writes only while the block is idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_max_x_ff <= SCREEN_BITS'(1023);
         screen_max_y_ff <= SCREEN_BITS'(767);
         plane_id_ff     <= '0;
         fb_handle_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SCREEN_MAX_X: screen_max_x_ff <= csr_wdata[SCREEN_BITS-1:0];
            REG_SCREEN_MAX_Y: screen_max_y_ff <= csr_wdata[SCREEN_BITS-1:0];
            REG_PLANE_ID:     plane_id_ff     <= csr_wdata[HANDLE_BITS-1:0];
            REG_FB_HANDLE:    fb_handle_ff    <= csr_wdata[HANDLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Motion: the first mouse item uses the relative delta, later ones the
   // difference between successive absolute coordinates.
   always_comb begin
      if (abs_seen_ff) begin
         delta_x = DELTA_BITS'(req_ff.abs_x) - DELTA_BITS'(prev_abs_x_ff);
         delta_y = DELTA_BITS'(req_ff.abs_y) - DELTA_BITS'(prev_abs_y_ff);
      end else begin
         delta_x = DELTA_BITS'(req_ff.rel_dx);
         delta_y = DELTA_BITS'(req_ff.rel_dy);
      end
   end

   assign center_x = center_of(screen_max_x_ff);
   assign center_y = center_of(screen_max_y_ff);
   assign is_start = (req_ff.action == ACT_START);

   // A start syncs from cleared output memory at the screen center; a tick syncs
   // from the current memory at the adopted goal.
   always_comb begin
      if (is_start) begin
         sync_src = SYNC_CLEAR;
         sync_x   = center_x;
         sync_y   = center_y;
         sync_b   = '0;
      end else begin
         sync_src = sync_st_ff;
         sync_x   = move_pending_ff ? goal_x_ff : cur_x_ff;
         sync_y   = move_pending_ff ? goal_y_ff : cur_y_ff;
         sync_b   = held_buttons_ff;
      end
   end

   cpt_sync u_sync (
      .st_in     (sync_src),
      .active    (req_ff.term_active),
      .tty       (req_ff.term_tty),
      .accepts   (req_ff.term_accepts),
      .pos_x     (sync_x),
      .pos_y     (sync_y),
      .buttons   (sync_b),
      .plane_id  (plane_id_ff),
      .fb_handle (fb_handle_ff),
      .st_out    (sync_res),
      .cmd_cnt   (sync_cnt),
      .cmds      (sync_cmds)
   );

   always_comb begin
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      goal_x_in       = goal_x_ff;
      goal_y_in       = goal_y_ff;
      prev_abs_x_in   = prev_abs_x_ff;
      prev_abs_y_in   = prev_abs_y_ff;
      abs_seen_in     = abs_seen_ff;
      held_buttons_in = held_buttons_ff;
      move_pending_in = move_pending_ff;
      sync_st_in      = sync_st_ff;
      push_cnt        = '0;

      if (fire) begin
         case (req_ff.action)
            ACT_MOUSE: begin
               abs_seen_in     = 1'b1;
               prev_abs_x_in   = req_ff.abs_x;
               prev_abs_y_in   = req_ff.abs_y;
               held_buttons_in = req_ff.button_mask;
               if ((delta_x != '0) || (delta_y != '0)) begin
                  goal_x_in       = sat_coord(goal_x_ff, delta_x,
                                              coord_limit(screen_max_x_ff));
                  goal_y_in       = sat_coord(goal_y_ff, delta_y,
                                              coord_limit(screen_max_y_ff));
                  move_pending_in = 1'b1;
               end else if (held_buttons_ff != req_ff.button_mask) begin
                  move_pending_in = 1'b1;
               end
            end
            ACT_TICK: begin
               cur_x_in        = sync_x;
               cur_y_in        = sync_y;
               sync_st_in      = sync_res;
               move_pending_in = 1'b0;
               push_cnt        = sync_cnt;
            end
            ACT_START: begin
               cur_x_in        = center_x;
               cur_y_in        = center_y;
               goal_x_in       = center_x;
               goal_y_in       = center_y;
               prev_abs_x_in   = '0;
               prev_abs_y_in   = '0;
               abs_seen_in     = 1'b0;
               held_buttons_in = '0;
               move_pending_in = 1'b0;
               sync_st_in      = sync_res;
               push_cnt        = sync_cnt;
            end
            default: begin
               // The unused kind is dropped without effect.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         goal_x_ff       <= '0;
         goal_y_ff       <= '0;
         prev_abs_x_ff   <= '0;
         prev_abs_y_ff   <= '0;
         abs_seen_ff     <= 1'b0;
         held_buttons_ff <= '0;
         move_pending_ff <= 1'b0;
         sync_st_ff      <= SYNC_CLEAR;
      end else begin
         cur_x_ff        <= cur_x_in;
         cur_y_ff        <= cur_y_in;
         goal_x_ff       <= goal_x_in;
         goal_y_ff       <= goal_y_in;
         prev_abs_x_ff   <= prev_abs_x_in;
         prev_abs_y_ff   <= prev_abs_y_in;
         abs_seen_ff     <= abs_seen_in;
         held_buttons_ff <= held_buttons_in;
         move_pending_ff <= move_pending_in;
         sync_st_ff      <= sync_st_in;
      end
   end

   // Commands wait in the queue until the consumer takes them.
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   cpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (sync_cmds),
      .pop       (rsp_xfer),
      .head      (q_head),
      .not_empty (q_not_empty),
      .room      (q_room)
   );

   assign rsp_tvalid   = q_not_empty;
   assign rsp_tuser[0] = q_head.command;
   assign rsp_tlast    = q_head.last;
   assign rsp_tdata    = {{(RSP_TDATA_BITS - RSP_PAYLOAD_BITS){1'b0}},
                          q_head.plane_out, q_head.fb_out, q_head.buttons_out,
                          q_head.pos_y, q_head.pos_x, q_head.shown,
                          q_head.target_tty};

endmodule

>>> rtl/core/cpt_checker.sv
// Port-level checks for the cursor tracker.
module cpt_checker
   import cpt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic [0:0]                rsp_tuser,
   input logic                      rsp_tlast
);

   // Nothing is left over from before a reset.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled command holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled command changed");

   // Plane commits carry no terminal or button content, and a hide carries no image.
   a_plane_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == CMD_PLANE) |->
         (rsp_tdata[7:0] == '0) && (rsp_tdata[48:41] == '0) &&
         (rsp_tdata[8] || (rsp_tdata[80:49] == '0)))
      else $error("plane commit with stray fields");

   // Terminal updates carry no framebuffer or plane.
   a_term_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == CMD_TERM) |->
         (rsp_tdata[80:49] == '0) && (rsp_tdata[112:81] == '0))
      else $error("terminal update with plane fields");

endmodule

bind cursor_position_tracker_unit cpt_checker u_checker (.*);

>>> verif/cursor_command_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port of the cursor tracker, keeps its
// own copy of the tracking state and compares each command with the oldest one
// predicted.
module cursor_command_checker
   import cpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [ACTION_BITS-1:0]    req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic [0:0]                rsp_tuser,
   input  logic                      rsp_tlast,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        outstanding
);

   // Field positions in the item and command payloads.
   localparam int Q_ABS_X   = 0;
   localparam int Q_ABS_Y   = MOUSE_BITS;
   localparam int Q_REL_DX  = 2 * MOUSE_BITS;
   localparam int Q_REL_DY  = 3 * MOUSE_BITS;
   localparam int Q_BTN     = 4 * MOUSE_BITS;
   localparam int Q_ACTIVE  = Q_BTN + BTN_BITS;
   localparam int Q_TTY     = Q_ACTIVE + 1;
   localparam int Q_ACCEPTS = Q_TTY + TTY_BITS;

   localparam int R_TTY   = 0;
   localparam int R_SHOWN = TTY_BITS;
   localparam int R_X     = R_SHOWN + 1;
   localparam int R_Y     = R_X + COORD_BITS;
   localparam int R_BTN   = R_Y + COORD_BITS;
   localparam int R_FB    = R_BTN + BTN_BITS;
   localparam int R_PLANE = R_FB + HANDLE_BITS;

   localparam logic [SCREEN_BITS-1:0] MAX_X_AT_RESET = 16'd1023;
   localparam logic [SCREEN_BITS-1:0] MAX_Y_AT_RESET = 16'd767;
   localparam int REPORT_LIMIT = 10;

   logic [SCREEN_BITS-1:0] max_x, max_y;
   logic [HANDLE_BITS-1:0] plane_obj, image_fb;

   coord_type              cur_x, cur_y, goal_x, goal_y;
   int                     prev_x, prev_y;
   bit                     abs_valid, move_pending;
   logic [BTN_BITS-1:0]    held_btn;

   // What the terminal and the plane were last told.
   bit                     term_on_screen;
   logic [TTY_BITS-1:0]    term_tty_sent;
   coord_type              term_x_sent, term_y_sent;
   logic [BTN_BITS-1:0]    term_btn_sent;
   logic [1:0]             plane_mode;
   coord_type              plane_x_sent, plane_y_sent;

   rsp_type                expected_cmds[$];
   rsp_type                batch[SYNC_MAX];
   int                     batch_n;
   int                     fails = 0;

   task automatic clear_tracking_state();
      cur_x = '0;
      cur_y = '0;
      goal_x = '0;
      goal_y = '0;
      prev_x = 0;
      prev_y = 0;
      abs_valid = 1'b0;
      held_btn = '0;
      move_pending = 1'b0;
      term_on_screen = 1'b0;
      term_tty_sent = '0;
      term_x_sent = '0;
      term_y_sent = '0;
      term_btn_sent = '0;
      plane_mode = MODE_UNKNOWN;
      plane_x_sent = '0;
      plane_y_sent = '0;
   endtask

   task automatic queue_cmd(input logic cmd, input logic [TTY_BITS-1:0] tty,
                            input logic shown, input coord_type x, input coord_type y,
                            input logic [BTN_BITS-1:0] btn,
                            input logic [HANDLE_BITS-1:0] fb,
                            input logic [HANDLE_BITS-1:0] plane);
      rsp_type c;
      if (batch_n < SYNC_MAX) begin
         c.command     = cmd;
         c.target_tty  = tty;
         c.shown       = shown;
         c.pos_x       = x;
         c.pos_y       = y;
         c.buttons_out = btn;
         c.fb_out      = fb;
         c.plane_out   = plane;
         c.last        = 1'b0;
         batch[batch_n] = c;
         batch_n++;
      end
   endtask

   function automatic coord_type clamp_to_screen(input coord_type g, input int d,
                                                 input logic [SCREEN_BITS-1:0] m);
      longint lim;
      longint v;
      lim = (longint'(m) > longint'(COORD_MASK)) ? longint'(COORD_MASK) : longint'(m);
      v = longint'(g) + longint'(d);
      if (v < 0) begin
         return '0;
      end
      if (v > lim) begin
         return coord_type'(lim);
      end
      return coord_type'(v);
   endfunction

   function automatic coord_type screen_center(input logic [SCREEN_BITS-1:0] m);
      return coord_type'((int'(m) + 1) / 2);
   endfunction

   // Sends only what differs from what each output last received. A terminal
   // that refuses the show still gets it, and the plane then takes over.
   task automatic run_sync(input bit active, input logic [TTY_BITS-1:0] tty,
                           input bit accepts);
      bit on_term;
      on_term = active;
      if (on_term) begin
         if (term_on_screen && term_tty_sent != tty) begin
            queue_cmd(CMD_TERM, term_tty_sent, 1'b0, term_x_sent, term_y_sent,
                      term_btn_sent, '0, '0);
            term_on_screen = 1'b0;
         end
         if (!term_on_screen || term_x_sent != cur_x || term_y_sent != cur_y ||
             term_btn_sent != held_btn) begin
            queue_cmd(CMD_TERM, tty, 1'b1, cur_x, cur_y, held_btn, '0, '0);
            if (!accepts) begin
               on_term = 1'b0;
            end else begin
               term_on_screen = 1'b1;
               term_tty_sent = tty;
               term_x_sent = cur_x;
               term_y_sent = cur_y;
               term_btn_sent = held_btn;
            end
         end
      end
      if (on_term) begin
         if (plane_mode != MODE_HIDDEN) begin
            queue_cmd(CMD_PLANE, '0, 1'b0, cur_x, cur_y, '0, '0, plane_obj);
            plane_mode = MODE_HIDDEN;
         end
      end else begin
         if (term_on_screen) begin
            queue_cmd(CMD_TERM, term_tty_sent, 1'b0, term_x_sent, term_y_sent,
                      term_btn_sent, '0, '0);
            term_on_screen = 1'b0;
         end
         if (plane_mode != MODE_SHOWN || plane_x_sent != cur_x || plane_y_sent != cur_y) begin
            queue_cmd(CMD_PLANE, '0, 1'b1, cur_x, cur_y, '0, image_fb, plane_obj);
            plane_mode = MODE_SHOWN;
            plane_x_sent = cur_x;
            plane_y_sent = cur_y;
         end
      end
   endtask

   task automatic predict_item(input logic [ACTION_BITS-1:0] act,
                               input logic [REQ_TDATA_BITS-1:0] d);
      int ax, ay, dx, dy;
      logic [BTN_BITS-1:0] btn;
      bit changed;
      batch_n = 0;
      case (act)
         ACT_MOUSE: begin
            ax = $signed(d[Q_ABS_X +: MOUSE_BITS]);
            ay = $signed(d[Q_ABS_Y +: MOUSE_BITS]);
            btn = d[Q_BTN +: BTN_BITS];
            if (abs_valid) begin
               dx = ax - prev_x;
               dy = ay - prev_y;
            end else begin
               dx = $signed(d[Q_REL_DX +: MOUSE_BITS]);
               dy = $signed(d[Q_REL_DY +: MOUSE_BITS]);
               abs_valid = 1'b1;
            end
            prev_x = ax;
            prev_y = ay;
            changed = (held_btn != btn);
            held_btn = btn;
            if (dx != 0 || dy != 0) begin
               goal_x = clamp_to_screen(goal_x, dx, max_x);
               goal_y = clamp_to_screen(goal_y, dy, max_y);
               move_pending = 1'b1;
            end else if (changed) begin
               move_pending = 1'b1;
            end
         end
         ACT_TICK: begin
            if (move_pending && (goal_x != cur_x || goal_y != cur_y)) begin
               cur_x = goal_x;
               cur_y = goal_y;
            end
            run_sync(d[Q_ACTIVE], d[Q_TTY +: TTY_BITS], d[Q_ACCEPTS]);
            move_pending = 1'b0;
         end
         ACT_START: begin
            clear_tracking_state();
            cur_x = screen_center(max_x);
            cur_y = screen_center(max_y);
            goal_x = cur_x;
            goal_y = cur_y;
            run_sync(d[Q_ACTIVE], d[Q_TTY +: TTY_BITS], d[Q_ACCEPTS]);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < batch_n; i++) begin
         if (i == batch_n - 1) begin
            batch[i].last = 1'b1;
         end
         expected_cmds.push_back(batch[i]);
      end
   endtask

   function automatic string describe(input rsp_type c);
      return $sformatf("cmd=%0d tty=%0d shown=%0d x=%0d y=%0d btn=%h fb=%h plane=%h last=%0d",
                       c.command, c.target_tty, c.shown, c.pos_x, c.pos_y,
                       c.buttons_out, c.fb_out, c.plane_out, c.last);
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_cmds.size() == 0) begin
         fails++;
         if (fails <= REPORT_LIMIT) begin
            $display("%0t: command with none expected: %s", $time, describe(got));
         end
      end else begin
         want = expected_cmds.pop_front();
         if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
               $display("%0t: command mismatch", $time);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      if (reset) begin
         max_x = MAX_X_AT_RESET;
         max_y = MAX_Y_AT_RESET;
         plane_obj = '0;
         image_fb = '0;
         clear_tracking_state();
         expected_cmds.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.command     = rsp_tuser[0];
            got.target_tty  = rsp_tdata[R_TTY +: TTY_BITS];
            got.shown       = rsp_tdata[R_SHOWN];
            got.pos_x       = rsp_tdata[R_X +: COORD_BITS];
            got.pos_y       = rsp_tdata[R_Y +: COORD_BITS];
            got.buttons_out = rsp_tdata[R_BTN +: BTN_BITS];
            got.fb_out      = rsp_tdata[R_FB +: HANDLE_BITS];
            got.plane_out   = rsp_tdata[R_PLANE +: HANDLE_BITS];
            got.last        = rsp_tlast;
            check_result(got);
         end
         if (req_tvalid && req_tready) begin
            predict_item(req_tuser, req_tdata);
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_SCREEN_MAX_X: max_x = csr_wdata[SCREEN_BITS-1:0];
               REG_SCREEN_MAX_Y: max_y = csr_wdata[SCREEN_BITS-1:0];
               REG_PLANE_ID:     plane_obj = csr_wdata[HANDLE_BITS-1:0];
               REG_FB_HANDLE:    image_fb = csr_wdata[HANDLE_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      fail_count <= fails;
      outstanding <= expected_cmds.size();
   end

endmodule

>>> verif/tb_cursor_position_tracker_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the cursor position tracker. A checker instance
// beside the block predicts every command and counts failures; this module
// only drives the item stream, the register port and the result back-pressure.
module tb_cursor_position_tracker_unit;
   import cpt_pkg::*;

   // The block ignores this item kind, so the package gives it no name.
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   localparam int RESET_CYCLES = 8;
   // An item is held in the input register before it executes; the drain time
   // covers any item that produces no command.
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 300000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [ACTION_BITS-1:0]    req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int fail_count;
   int outstanding;
   int cycles = 0;

   // Idle percentages of the two sides, changed from phase to phase.
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;

   // A long receiver hold is requested by bumping hold_requests; the receiver
   // process notices the change and counts the stretch down itself.
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Pointer and terminal state that the random items evolve, so that most
   // mouse items are small believable moves rather than noise.
   logic signed [MOUSE_BITS-1:0] ptr_x = '0;
   logic signed [MOUSE_BITS-1:0] ptr_y = '0;
   logic [BTN_BITS-1:0]          buttons_now = '0;
   bit                           term_on = 1'b0;
   logic [TTY_BITS-1:0]          term_no = 8'd1;

   cursor_position_tracker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cursor_command_checker u_cmd_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A run that hangs or loses commands ends here instead of running forever.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result back-pressure: random stalls at the phase's rate, or a long hold
   // when one has been requested.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic req_type compose_item(input logic [ACTION_BITS-1:0] act,
                                            input int ax, input int ay,
                                            input int rx, input int ry,
                                            input int btn, input int active,
                                            input int tty, input int accepts);
      req_type r;
      r.action       = act;
      r.abs_x        = MOUSE_BITS'(ax);
      r.abs_y        = MOUSE_BITS'(ay);
      r.rel_dx       = MOUSE_BITS'(rx);
      r.rel_dy       = MOUSE_BITS'(ry);
      r.button_mask  = BTN_BITS'(btn);
      r.term_active  = 1'(active);
      r.term_tty     = TTY_BITS'(tty);
      r.term_accepts = 1'(accepts);
      return r;
   endfunction

   // Offers one item, with a random gap in front of it at the phase's idle
   // rate, and returns at the edge where the transfer takes place. The valid
   // stays high afterwards, so the caller either offers the next item or
   // lowers it in the same step.
   task automatic offer(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= REQ_TDATA_BITS'({it.term_accepts, it.term_tty, it.term_active,
                                     it.button_mask, it.rel_dy, it.rel_dx,
                                     it.abs_y, it.abs_x});
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // Stops offering and waits until every predicted command has been
   // transferred, then lets the block settle. The first edge lets the checker
   // take in the item of the final transfer.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [SCREEN_BITS-1:0] mx,
                                 input logic [SCREEN_BITS-1:0] my,
                                 input logic [HANDLE_BITS-1:0] pid,
                                 input logic [HANDLE_BITS-1:0] fbh);
      csr_put(REG_SCREEN_MAX_X, CSR_DATA_BITS'(mx));
      csr_put(REG_SCREEN_MAX_Y, CSR_DATA_BITS'(my));
      csr_put(REG_PLANE_ID, pid);
      csr_put(REG_FB_HANDLE, fbh);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small moves and frame ticks, with occasional starts, jumps,
   // idle moves, button changes, fully random mouse items and unused kinds.
   // Fields that an item kind ignores still carry random bits.
   task automatic random_items(input int count);
      int pick;
      int step_x;
      int step_y;
      req_type it;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         it = compose_item(ACT_MOUSE, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
         if (pick < 4) begin
            it.action = ACT_START;
         end else if (pick < 6) begin
            it.action = ACT_UNUSED;
         end else if (pick < 10) begin
            ptr_x = it.abs_x;
            ptr_y = it.abs_y;
            buttons_now = it.button_mask;
         end else if (pick < 60) begin
            if ($urandom_range(9) == 0) begin
               step_x = int'($urandom_range(4000)) - 2000;
               step_y = int'($urandom_range(4000)) - 2000;
            end else if ($urandom_range(7) == 0) begin
               step_x = 0;
               step_y = 0;
            end else begin
               step_x = int'($urandom_range(80)) - 40;
               step_y = int'($urandom_range(80)) - 40;
            end
            ptr_x = ptr_x + MOUSE_BITS'(step_x);
            ptr_y = ptr_y + MOUSE_BITS'(step_y);
            if ($urandom_range(6) == 0) begin
               buttons_now = buttons_now ^ BTN_BITS'(1 << $urandom_range(BTN_BITS - 1));
            end
            it.abs_x = ptr_x;
            it.abs_y = ptr_y;
            it.button_mask = buttons_now;
            // The relative delta only counts on the first move after a start,
            // where a small one keeps the pointer on the screen.
            if ($urandom_range(1) == 0) begin
               it.rel_dx = MOUSE_BITS'(int'($urandom_range(200)) - 100);
               it.rel_dy = MOUSE_BITS'(int'($urandom_range(200)) - 100);
            end
         end else begin
            it.action = ACT_TICK;
         end
         if (it.action == ACT_TICK || it.action == ACT_START) begin
            if ($urandom_range(4) == 0) begin
               term_on = !term_on;
            end
            if ($urandom_range(9) == 0) begin
               term_no = TTY_BITS'($urandom);
            end
            it.term_active = term_on;
            it.term_tty = term_no;
            it.term_accepts = ($urandom_range(99) < 85);
         end
         offer(it);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Phase one: the sender idles a third of the time, the receiver mostly.
      send_idle_pct = 33;
      rcv_idle_pct = 79;

      // Directed items, with the register values from reset. A move before
      // any start works from the cleared state; its relative delta is used.
      offer(compose_item(ACT_MOUSE, 100, 200, 5, -3, 8'h00, 0, 0, 0));
      // The plane starts out neither shown nor hidden, so it is committed.
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1));
      offer(compose_item(ACT_UNUSED, -1, -1, -1, -1, 8'hFF, 1, 8'hFF, 1));
      // Start on an accepting terminal: show it and hide the plane.
      offer(compose_item(ACT_START, 0, 0, 0, 0, 0, 1, 3, 1));
      // First move after a start, with extreme relative deltas saturating
      // both axes to the screen edges.
      offer(compose_item(ACT_MOUSE, 32767, -32768, -32768, 32767, 8'h00, 0, 0, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 3, 1));
      // The largest absolute jump in both directions, with every button down.
      offer(compose_item(ACT_MOUSE, -32768, 32767, 0, 0, 8'hFF, 0, 0, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 3, 1));
      // An idle move leaves nothing pending, so the tick sends nothing.
      offer(compose_item(ACT_MOUSE, -32768, 32767, 77, -77, 8'hFF, 1, 9, 1));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 3, 1));
      offer(compose_item(ACT_MOUSE, -32668, 32717, 0, 0, 8'hFF, 0, 0, 0));
      // A change of terminal hides the old one before showing the new one.
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 7, 1));
      offer(compose_item(ACT_MOUSE, -32658, 32717, 0, 0, 8'h00, 0, 0, 0));
      // Refused show: the terminal still gets it, then the plane takes over.
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 7, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 7, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 7, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 8'hFF, 1));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 8'hFF, 1));
      // A start without a terminal recenters on the plane.
      offer(compose_item(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0));
      offer(compose_item(ACT_MOUSE, 500, -500, 0, 0, 8'h00, 0, 0, 0));
      offer(compose_item(ACT_MOUSE, 480, -470, 0, 0, 8'h81, 0, 0, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 0, 0));
      offer(compose_item(ACT_TICK, 0, 0, 0, 0, 0, 1, 0, 1));
      wait_drained();

      write_settings(16'd639, 16'd479, $urandom, $urandom);
      random_items(60);
      wait_drained();

      // Phase two: the other way round, on a one-pixel screen.
      send_idle_pct = 79;
      rcv_idle_pct = 33;
      write_settings(16'd0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      random_items(40);
      wait_drained();

      // Phase three: no idling on either side, on the largest screen. In the
      // middle the receiver holds off for a long stretch while ticks that switch
      // the terminal on and off, each after the first causing two commands, keep
      // coming, so the block backs up into its input.
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      write_settings(16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      random_items(30);
      hold_requests = hold_requests + 1;
      for (int k = 0; k < 12; k++) begin
         offer(compose_item(ACT_TICK, $urandom, $urandom, $urandom, $urandom,
                            $urandom, k % 2, 9, 1));
      end
      random_items(30);
      wait_drained();

      write_settings(MOUSE_BITS'($urandom), MOUSE_BITS'($urandom), $urandom, $urandom);
      random_items(40);
      wait_drained();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
